FILE: rtl/core/rbaf_pkg.sv
`default_nettype none

package rbaf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 7;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
   localparam int RING_W    = $clog2(RING_ROWS);
   localparam int ADDR_W    = RING_W + COL_W;
   localparam int SPAN_W    = $clog2(2 * MAX_RADIUS + 2);
   localparam int COUNT_W   = 2 * SPAN_W;
   localparam int SUM_W     = 8 + COUNT_W;
   localparam int DIV_CNT_W = $clog2(SUM_W);
   localparam int CFG_W     = 11;
   localparam int RAD_W     = 3;
   localparam int CSR_IDX_W = 4;
   localparam int PIX_W     = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_Y     = 4'd3;

   typedef struct packed {
      logic [COL_W-1:0] x0;
      logic [COL_W-1:0] x1;
      logic [ROW_W-1:0] y0;
      logic [ROW_W-1:0] y1;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  data;
   } wr_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SUM,
      B_DIV,
      B_OUT
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/rbaf_queue.sv
`default_nettype none

module rbaf_queue import rbaf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       full;

   assign empty    = (fill_ff == 2'd0);
   assign full     = (fill_ff == 2'd2);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !full) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop && !empty) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if ((push && !full) && !(pop && !empty)) begin
         fill_in = fill_ff + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rbaf_front.sv
`default_nettype none

module rbaf_front import rbaf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [7:0]           req_red_in,
   input  logic [7:0]           req_green_in,
   input  logic [7:0]           req_blue_in,
   input  logic                 queue_empty,
   input  logic                 back_reading,
   output logic                 cmd_push,
   output cmd_type              cmd,
   output wr_type               wr
);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [RAD_W-1:0] rx_ff, rx_in;
   logic [RAD_W-1:0] ry_ff, ry_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             frame_in_ff, frame_in_in;

   logic [CFG_W-1:0] w_eff, h_eff;
   logic [COL_W-1:0] w_max;
   logic [ROW_W-1:0] h_max;
   logic             accept, store, complete, last;
   logic [COL_W-1:0] ic_a, need_x, x0;
   logic [ROW_W-1:0] ir_a, need_y, y0;
   logic             fi_a;
   logic [CFG_W-1:0] x_reach, y_reach;

   // pixels only enter while nothing waits to read the row ring
   assign req_ready = queue_empty && !back_reading;
   assign accept    = req_valid && req_ready;
   assign store     = accept && !req_mode && !frame_in_ff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (width_ff > CFG_W'(MAX_WIDTH)) begin
         w_eff = CFG_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (height_ff > CFG_W'(MAX_HEIGHT)) begin
         h_eff = CFG_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      w_max = COL_W'(w_eff - CFG_W'(1));
      h_max = ROW_W'(h_eff - CFG_W'(1));

      ic_a = in_col_ff;
      ir_a = in_row_ff;
      fi_a = frame_in_ff;
      if (store) begin
         if ({1'b0, in_col_ff} + CFG_W'(1) >= w_eff) begin
            ic_a = '0;
            if ({1'b0, in_row_ff} + CFG_W'(1) >= h_eff) begin
               ir_a = '0;
               fi_a = 1'b1;
            end else begin
               ir_a = in_row_ff + ROW_W'(1);
            end
         end else begin
            ic_a = in_col_ff + COL_W'(1);
         end
      end

      x_reach = {1'b0, out_col_ff} + CFG_W'(rx_ff);
      y_reach = {1'b0, out_row_ff} + CFG_W'(ry_ff);
      need_x  = (x_reach > {1'b0, w_max}) ? w_max : COL_W'(x_reach);
      need_y  = (y_reach > {1'b0, h_max}) ? h_max : ROW_W'(y_reach);
      x0 = (out_col_ff > COL_W'(rx_ff)) ? out_col_ff - COL_W'(rx_ff) : '0;
      y0 = (out_row_ff > ROW_W'(ry_ff)) ? out_row_ff - ROW_W'(ry_ff) : '0;

      complete = fi_a || (ir_a > need_y) || ((ir_a == need_y) && (ic_a > need_x));
      last     = ({1'b0, out_col_ff} + CFG_W'(1) >= w_eff)
                 && ({1'b0, out_row_ff} + CFG_W'(1) >= h_eff);

      cmd_push = accept && complete;
      cmd.x0   = x0;
      cmd.x1   = need_x;
      cmd.y0   = y0;
      cmd.y1   = need_y;
      cmd.last = last;

      wr.en   = store;
      wr.addr = {RING_W'(in_row_ff % RING_ROWS), in_col_ff};
      wr.data = {req_red_in, req_green_in, req_blue_in};

      width_in    = width_ff;
      height_in   = height_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      in_col_in   = ic_a;
      in_row_in   = ir_a;
      frame_in_in = fi_a;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;

      if (cmd_push) begin
         if ({1'b0, out_col_ff} + CFG_W'(1) >= w_eff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
         if (last) begin
            in_col_in   = '0;
            in_row_in   = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            frame_in_in = 1'b0;
         end
      end

      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            CSR_RADIUS_X:     rx_in     = csr_write_data[RAD_W-1:0];
            CSR_RADIUS_Y:     ry_in     = csr_write_data[RAD_W-1:0];
            default:          ;
         endcase
         if (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT
             || csr_index == CSR_RADIUS_X || csr_index == CSR_RADIUS_Y) begin
            in_col_in   = '0;
            in_row_in   = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            frame_in_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CFG_W'(640);
         height_ff   <= CFG_W'(480);
         rx_ff       <= RAD_W'(1);
         ry_ff       <= RAD_W'(1);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         frame_in_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         rx_ff       <= rx_in;
         ry_ff       <= ry_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         frame_in_ff <= frame_in_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rbaf_back.sv
`default_nettype none

module rbaf_back import rbaf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  wr_type     wr,
   input  logic       queue_empty,
   input  cmd_type    queue_data,
   output logic       queue_pop,
   output logic       back_reading,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   output logic       rsp_frame_end
);

   logic [PIX_W-1:0] ring_mem [RING_ROWS * MAX_WIDTH];
   logic [PIX_W-1:0] rdata_ff;

   back_state_type   state_ff, state_in;
   cmd_type          job_ff, job_in;
   logic [COL_W-1:0] x_ff, x_in;
   logic [ROW_W-1:0] y_ff, y_in;
   logic             issuing_ff, issuing_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_en;
   logic [ADDR_W-1:0] raddr;
   logic [SUM_W-1:0] num_ff [3];
   logic [SUM_W-1:0] num_in [3];
   logic [7:0]       rem_ff [3];
   logic [7:0]       rem_in [3];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic             end_ff, end_in;
   logic [8:0]       rem_sh [3];
   logic [SPAN_W-1:0] span_x, span_y;

   assign back_reading  = (state_ff == B_SUM);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_frame_end = end_ff;
   assign raddr         = {RING_W'(y_ff % RING_ROWS), x_ff};

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      issuing_in   = issuing_ff;
      rd_pend_in   = 1'b0;
      rd_en        = 1'b0;
      count_in     = count_ff;
      step_in      = step_ff;
      queue_pop    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      end_in       = end_ff;
      span_x       = SPAN_W'(queue_data.x1 - queue_data.x0) + SPAN_W'(1);
      span_y       = SPAN_W'(queue_data.y1 - queue_data.y0) + SPAN_W'(1);
      for (int c = 0; c < 3; c++) begin
         num_in[c] = num_ff[c];
         rem_in[c] = rem_ff[c];
         rem_sh[c] = {rem_ff[c], num_ff[c][SUM_W-1]};
      end

      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               queue_pop  = 1'b1;
               job_in     = queue_data;
               x_in       = queue_data.x0;
               y_in       = queue_data.y0;
               issuing_in = 1'b1;
               count_in   = COUNT_W'(span_x) * COUNT_W'(span_y);
               for (int c = 0; c < 3; c++) begin
                  num_in[c] = '0;
               end
               state_in = B_SUM;
            end
         end
         B_SUM: begin
            if (issuing_ff) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               if (x_ff == job_ff.x1) begin
                  x_in = job_ff.x0;
                  if (y_ff == job_ff.y1) begin
                     issuing_in = 1'b0;
                  end else begin
                     y_in = y_ff + ROW_W'(1);
                  end
               end else begin
                  x_in = x_ff + COL_W'(1);
               end
            end
            if (rd_pend_ff) begin
               num_in[0] = num_ff[0] + SUM_W'(rdata_ff[23:16]);
               num_in[1] = num_ff[1] + SUM_W'(rdata_ff[15:8]);
               num_in[2] = num_ff[2] + SUM_W'(rdata_ff[7:0]);
            end
            if (!issuing_ff && !rd_pend_ff) begin
               for (int c = 0; c < 3; c++) begin
                  rem_in[c] = '0;
               end
               step_in  = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            // restoring division, one quotient bit per cycle
            for (int c = 0; c < 3; c++) begin
               if (rem_sh[c] >= {1'b0, count_ff}) begin
                  rem_in[c] = 8'(rem_sh[c] - {1'b0, count_ff});
                  num_in[c] = {num_ff[c][SUM_W-2:0], 1'b1};
               end else begin
                  rem_in[c] = rem_sh[c][7:0];
                  num_in[c] = {num_ff[c][SUM_W-2:0], 1'b0};
               end
            end
            step_in = step_ff + DIV_CNT_W'(1);
            if (step_ff == DIV_CNT_W'(SUM_W - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               red_in       = num_ff[0][7:0];
               green_in     = num_ff[1][7:0];
               blue_in      = num_ff[2][7:0];
               end_in       = job_ff.last;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         issuing_ff   <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issuing_ff   <= issuing_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      count_ff <= count_in;
      step_ff  <= step_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      end_ff   <= end_in;
      for (int c = 0; c < 3; c++) begin
         num_ff[c] <= num_in[c];
         rem_ff[c] <= rem_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ring_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff <= ring_mem[raddr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_box_average_filter.sv
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_mode, req_red_in, req_green_in, req_blue_in
// rsp      out        rsp_valid/rsp_ready  rsp_red_out, rsp_green_out, rsp_blue_out,
//                                          rsp_frame_end
// csr      in         csr_write_enable     csr_index, csr_write_data
//
// an item that releases a result holds req while the window is summed one pixel a cycle
// from the single read port of the row ring; its result shows once a 16-step divider
// has the mean.
// an item that releases nothing starts no window sum.
// reset is synchronous; the row ring is not cleared, every entry is written before use.
// a stalled rsp holds one finished result while the next is computed.
`default_nettype none

module rgb_box_average_filter import rbaf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [7:0]           req_red_in,
   input  logic [7:0]           req_green_in,
   input  logic [7:0]           req_blue_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_red_out,
   output logic [7:0]           rsp_green_out,
   output logic [7:0]           rsp_blue_out,
   output logic                 rsp_frame_end
);

   cmd_type push_cmd, pop_cmd;
   wr_type  wr;
   logic    cmd_push, queue_pop, queue_empty, back_reading;

   rbaf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .queue_empty      (queue_empty),
      .back_reading     (back_reading),
      .cmd_push         (cmd_push),
      .cmd              (push_cmd),
      .wr               (wr)
   );

   rbaf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .pop       (queue_pop),
      .pop_data  (pop_cmd),
      .empty     (queue_empty)
   );

   rbaf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .wr            (wr),
      .queue_empty   (queue_empty),
      .queue_data    (pop_cmd),
      .queue_pop     (queue_pop),
      .back_reading  (back_reading),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

FILE: rtl/core/rbaf_checker.sv
`default_nettype none

module rbaf_checker import rbaf_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out,
   input logic       rsp_frame_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_end))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not open right after reset");

   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}))
      else $error("handshake output unknown");

endmodule

bind rgb_box_average_filter rbaf_checker u_rbaf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_frame_end (rsp_frame_end)
);

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rbaf_pkg::*;

   typedef struct {
      bit       mode;
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
   } pixel_item_t;

   typedef struct {
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit       frame_end;
   } mean_pixel_t;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_write_data = '0;
   logic                 req_valid = 0;
   logic                 req_ready;
   logic                 req_mode = 0;
   logic [7:0]           req_red_in = '0;
   logic [7:0]           req_green_in = '0;
   logic [7:0]           req_blue_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   logic [7:0]           rsp_red_out;
   logic [7:0]           rsp_green_out;
   logic [7:0]           rsp_blue_out;
   logic                 rsp_frame_end;

   rgb_box_average_filter i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   pixel_item_t pixel_q[$];
   mean_pixel_t mean_q[$];
   int          items_queued = 0;
   int          items_accepted = 0;
   int          means_seen = 0;
   int          frames_seen = 0;
   int          errors = 0;
   bit          calm = 0;
   bit          hold_go = 0;
   bit          hold_started = 0;
   int          hold_left = 0;

   // filter state mirror
   int          img_w = 640, img_h = 480, rad_x = 1, rad_y = 1;
   int          in_col = 0, in_row = 0, out_col = 0, out_row = 0;
   bit          frame_full = 0;
   bit [23:0]   ring [RING_ROWS][MAX_WIDTH];

   function automatic int eff_w();
      return img_w < 1 ? 1 : (img_w > MAX_WIDTH ? MAX_WIDTH : img_w);
   endfunction

   function automatic int eff_h();
      return img_h < 1 ? 1 : (img_h > MAX_HEIGHT ? MAX_HEIGHT : img_h);
   endfunction

   function automatic int eff_r(int r);
      return r > MAX_RADIUS ? MAX_RADIUS : r;
   endfunction

   task automatic restart_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_full = 0;
   endtask

   task automatic predict_mean(pixel_item_t it);
      int          w, h, rx, ry, need_x, need_y, x0, y0, cnt;
      int          sr, sg, sb;
      bit [23:0]   px;
      mean_pixel_t m;
      w = eff_w();
      h = eff_h();
      rx = eff_r(rad_x);
      ry = eff_r(rad_y);
      if (!it.mode && !frame_full) begin
         ring[in_row % RING_ROWS][in_col % MAX_WIDTH] = {it.red, it.green, it.blue};
         if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row + 1 >= h) begin
               in_row = 0;
               frame_full = 1;
            end else begin
               in_row++;
            end
         end else begin
            in_col++;
         end
      end
      need_x = out_col + rx > w - 1 ? w - 1 : out_col + rx;
      need_y = out_row + ry > h - 1 ? h - 1 : out_row + ry;
      if (!(frame_full || in_row > need_y || (in_row == need_y && in_col > need_x)))
         return;
      x0 = out_col > rx ? out_col - rx : 0;
      y0 = out_row > ry ? out_row - ry : 0;
      sr = 0;
      sg = 0;
      sb = 0;
      for (int y = y0; y <= need_y; y++) begin
         for (int x = x0; x <= need_x; x++) begin
            px = ring[y % RING_ROWS][x % MAX_WIDTH];
            sr += px[23:16];
            sg += px[15:8];
            sb += px[7:0];
         end
      end
      cnt = (need_x - x0 + 1) * (need_y - y0 + 1);
      m.red = sr / cnt;
      m.green = sg / cnt;
      m.blue = sb / cnt;
      m.frame_end = 0;
      if (out_col + 1 >= w) begin
         out_col = 0;
         if (out_row + 1 >= h) begin
            m.frame_end = 1;
            restart_frame();
         end else begin
            out_row++;
         end
      end else begin
         out_col++;
      end
      mean_q.push_back(m);
   endtask

   task automatic report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin : drive_req
      pixel_item_t it;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
            it = pixel_q.pop_front();
            req_valid <= 1;
            req_mode <= it.mode;
            req_red_in <= it.red;
            req_green_in <= it.green;
            req_blue_in <= it.blue;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin : watch_rsp
      pixel_item_t it;
      mean_pixel_t m;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it.mode = req_mode;
            it.red = req_red_in;
            it.green = req_green_in;
            it.blue = req_blue_in;
            predict_mean(it);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            means_seen++;
            if (rsp_frame_end) frames_seen++;
            if (mean_q.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               m = mean_q.pop_front();
               if (rsp_red_out !== m.red)
                  report_mismatch($sformatf("red %0d, want %0d", rsp_red_out, m.red));
               if (rsp_green_out !== m.green)
                  report_mismatch($sformatf("green %0d, want %0d", rsp_green_out, m.green));
               if (rsp_blue_out !== m.blue)
                  report_mismatch($sformatf("blue %0d, want %0d", rsp_blue_out, m.blue));
               if (rsp_frame_end !== m.frame_end)
                  report_mismatch($sformatf("frame_end %0d, want %0d",
                                            rsp_frame_end, m.frame_end));
            end
         end
      end
      // one long hold-off lets the block back up into its input
      if (hold_go && !hold_started) begin
         hold_started <= 1;
         hold_left <= 600;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 8;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_IMAGE_WIDTH:  img_w = data;
         CSR_IMAGE_HEIGHT: img_h = data;
         CSR_RADIUS_X:     rad_x = data[RAD_W-1:0];
         CSR_RADIUS_Y:     rad_y = data[RAD_W-1:0];
         default:          ;
      endcase
      if (idx <= CSR_RADIUS_Y) restart_frame();
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic setup(int w, int h, int rx, int ry);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_RADIUS_X, rx);
      write_reg(CSR_RADIUS_Y, ry);
   endtask

   task automatic push_item(bit mode, bit [7:0] r, bit [7:0] g, bit [7:0] b);
      pixel_item_t it;
      it.mode = mode;
      it.red = r;
      it.green = g;
      it.blue = b;
      pixel_q.push_back(it);
      items_queued++;
   endtask

   task automatic push_random(bit mode);
      push_item(mode, $urandom, $urandom, $urandom);
   endtask

   // waits for the block to drain, then lets a slow result finish
   task automatic drain();
      while (items_accepted != items_queued || mean_q.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // well-formed frame, optional stray flushes, enough trailing flushes to empty it
   task automatic push_frame(int w, int h, int rx, int ry);
      int tail;
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(19) == 0) push_random(1);
         push_random(0);
      end
      tail = (ry + 1) * w + rx + 1;
      if (tail > w * h) tail = w * h;
      for (int i = 0; i <= tail; i++)
         push_random($urandom_range(5) != 0);
   endtask

   initial begin : main
      int w, h, rx, ry, budget;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: 4x3 frame with extremes, early flush, pixel after frame
      setup(4, 3, 1, 1);
      push_item(1, 8'hFF, 8'hFF, 8'hFF);
      for (int i = 0; i < 12; i++)
         push_item(0, i[0] ? 8'hFF : 8'h00, i[1] ? 8'h00 : 8'hFF, 8'hFF);
      push_item(0, 8'h12, 8'h34, 8'h56);
      for (int i = 0; i < 6; i++) push_item(1, 8'h00, 8'h00, 8'h00);
      push_item(1, 8'hAA, 8'h55, 8'hAA);
      drain();

      // width zero clamps to one, radii at top with extra high data bits
      setup(0, 3, 11'h7FF, 11'h7FF);
      for (int i = 0; i < 3; i++) push_random(0);
      for (int i = 0; i < 3; i++) push_random(1);
      drain();

      // oversized width clamps, partial row then restart by reconfig
      setup(11'h7FF, 1, 0, 0);
      for (int i = 0; i < 4; i++) push_random(0);
      drain();
      setup(1, 11'h7FF, 0, 7);
      for (int i = 0; i < 20; i++) push_random(0);
      drain();

      // unknown register index in mid-frame must not disturb it
      setup(3, 3, 1, 2);
      for (int i = 0; i < 5; i++) push_random(0);
      drain();
      write_reg(4'hF, 11'h7FF);
      write_reg(4'h4, 11'h000);
      for (int i = 0; i < 4; i++) push_random(0);
      for (int i = 0; i < 10; i++) push_random(1);
      drain();

      // random frames
      budget = items_queued + 600;
      while (items_queued < budget) begin
         calm = ($urandom_range(9) == 0);
         if ($urandom_range(7) == 0) begin
            w = $urandom_range(16, 40);
            h = $urandom_range(1, 4);
         end else begin
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 6);
         end
         rx = $urandom_range(0, 7);
         ry = $urandom_range(0, 7);
         setup(w, h, rx | ($urandom_range(255) << 3), ry);
         w = eff_w();
         h = eff_h();
         if (!hold_go && items_queued > budget - 400) hold_go = 1;
         for (int f = $urandom_range(1, 3); f > 0; f--) begin
            if ($urandom_range(9) == 0) begin
               for (int i = $urandom_range(1, 2 * w * h); i > 0; i--)
                  push_random($urandom_range(2) == 0);
            end else begin
               push_frame(w, h, eff_r(rad_x), eff_r(rad_y));
            end
         end
         drain();
      end
      calm = 0;

      $display("items accepted: %0d, mean pixels checked: %0d, frames closed: %0d",
               items_accepted, means_seen, frames_seen);
      $display("sizes up to 40 wide and clamped extremes, radii 0 to 7, with stalls");
      if (errors == 0)
         $display("[rgb_box_average_filter] OK");
      else
         $display("[rgb_box_average_filter] ERROR");
      $finish;
   end

   initial begin : watchdog
      #8ms;
      $display("[rgb_box_average_filter] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

FILE: rgb_box_average_filter.f
rtl/core/rbaf_pkg.sv
rtl/core/rbaf_queue.sv
rtl/core/rbaf_front.sv
rtl/core/rbaf_back.sv
rtl/core/rgb_box_average_filter.sv
rtl/core/rbaf_checker.sv
verif/tb_top.sv
